// ===== design/mbcu_pkg.sv =====
// Shared types and constants for the motor bridge command unit.
package mbcu_pkg;

  // Command codes; the two spare codes are ignored
  typedef enum logic [2:0] {
    MODE_DEBUG   = 3'd0,
    MODE_ARM     = 3'd1,
    MODE_SPEED   = 3'd2,
    MODE_STOP    = 3'd3,
    MODE_LED     = 3'd4,
    MODE_READ    = 3'd5,
    MODE_SPARE_A = 3'd6,
    MODE_SPARE_B = 3'd7
  } mbcu_mode_e;

  // Register addresses for the read command
  localparam logic [7:0] RegVersion  = 8'd0;
  localparam logic [7:0] RegBattery  = 8'd1;
  localparam logic [7:0] RegEscCur   = 8'd2;
  localparam logic [7:0] RegHostCur  = 8'd3;
  localparam logic [7:0] RegPower    = 8'd4;
  localparam logic [7:0] RegArmed    = 8'd5;
  localparam logic [7:0] RegSpeeds   = 8'd6;
  localparam logic [7:0] RegCheck    = 8'd7;
  localparam logic [7:0] RegDebug    = 8'd8;

  localparam logic [7:0]  FlagOn     = 8'h01;
  localparam logic [15:0] SpeedMax   = 16'd2047;
  localparam logic [7:0]  VersionHi  = 8'h01;
  localparam logic [7:0]  VersionLo  = 8'h02;
  localparam logic [7:0]  BadRegHi   = 8'h0B;
  localparam logic [7:0]  BadRegLo   = 8'hAD;

  // One command word as held in the input register
  typedef struct packed {
    logic [2:0]       mode;
    logic [7:0]       arg_byte;
    logic [3:0][15:0] speed;
    logic [15:0]      battery_mv;
    logic [15:0]      esc_ma;
    logic [15:0]      host_ma;
    logic [15:0]      command_echo;
    logic [15:0]      link_check;
  } mbcu_cmd_t;

  // One result word
  typedef struct packed {
    logic [63:0]      reply_data;
    logic [3:0]       reply_length;
    logic [3:0][10:0] drive;
    logic             drive_updated;
    logic             is_armed;
    logic             in_debug;
    logic             led_on;
  } mbcu_res_t;

endpackage

// ===== design/mbcu_in_stage.sv =====
// Input register stage: captures one command word and holds it until it moves on.
module mbcu_in_stage
  import mbcu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  mbcu_cmd_t cmd_i,
  input  logic      advance_i,
  output logic      stage_valid_o,
  output mbcu_cmd_t cmd_o
);

  logic      valid_q, valid_d;
  mbcu_cmd_t cmd_q;
  logic      accept;

  // Free slot, or the held word leaves this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
  end

  assign stage_valid_o = valid_q;
  assign cmd_o         = cmd_q;

endmodule

// ===== design/mbcu_exec.sv =====
// Command execution: flag and speed state plus the result logic for one command.
module mbcu_exec
  import mbcu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  mbcu_cmd_t cmd_i,
  output mbcu_res_t res_o
);

  logic             armed_q, armed_d;
  logic             debug_q, debug_d;
  logic             led_q, led_d;
  logic [3:0][10:0] speed_q, speed_d;
  logic             upd;
  logic             flag_arg;
  logic             speeds_ok;
  logic [63:0]      reply_data;
  logic [3:0]       reply_len;

  assign flag_arg  = (cmd_i.arg_byte == FlagOn);
  assign speeds_ok = (cmd_i.speed[0] <= SpeedMax) && (cmd_i.speed[1] <= SpeedMax) &&
                     (cmd_i.speed[2] <= SpeedMax) && (cmd_i.speed[3] <= SpeedMax);

  // Next state
  always_comb begin
    armed_d = armed_q;
    debug_d = debug_q;
    led_d   = led_q;
    speed_d = speed_q;
    upd     = 1'b0;
    case (cmd_i.mode)
      MODE_DEBUG: begin
        debug_d = flag_arg && !armed_q;
        if (!debug_d) begin
          armed_d = 1'b0;
          speed_d = '0;
          upd     = 1'b1;
        end
      end
      MODE_ARM: begin
        armed_d = flag_arg;
        speed_d = '0;
        upd     = 1'b1;
      end
      MODE_SPEED: begin
        if (armed_q && speeds_ok) begin
          for (int i = 0; i < 4; i++) begin
            speed_d[i] = cmd_i.speed[i][10:0];
          end
          upd = 1'b1;
        end
      end
      MODE_STOP: begin
        speed_d = '0;
        upd     = 1'b1;
      end
      MODE_LED: begin
        led_d = flag_arg;
      end
      default: begin
      end
    endcase
  end

  // Register read reply, packed from the top byte
  always_comb begin
    reply_data = '0;
    reply_len  = 4'd0;
    if (cmd_i.mode == MODE_READ) begin
      case (cmd_i.arg_byte)
        RegVersion: begin
          reply_data = {VersionHi, VersionLo, 48'd0};
          reply_len  = 4'd2;
        end
        RegBattery: begin
          reply_data = {cmd_i.battery_mv, 48'd0};
          reply_len  = 4'd2;
        end
        RegEscCur: begin
          reply_data = {cmd_i.esc_ma, 48'd0};
          reply_len  = 4'd2;
        end
        RegHostCur: begin
          reply_data = {cmd_i.host_ma, 48'd0};
          reply_len  = 4'd2;
        end
        RegPower: begin
          reply_data = {cmd_i.battery_mv, cmd_i.esc_ma, cmd_i.host_ma, 16'd0};
          reply_len  = 4'd6;
        end
        RegArmed: begin
          reply_data = {7'd0, armed_q, 56'd0};
          reply_len  = 4'd1;
        end
        RegSpeeds: begin
          reply_data = {5'd0, speed_q[0], 5'd0, speed_q[1],
                        5'd0, speed_q[2], 5'd0, speed_q[3]};
          reply_len  = 4'd8;
        end
        RegCheck: begin
          reply_data = {cmd_i.command_echo, cmd_i.link_check, 32'd0};
          reply_len  = 4'd4;
        end
        RegDebug: begin
          reply_data = {7'd0, debug_q, 56'd0};
          reply_len  = 4'd1;
        end
        default: begin
          reply_data = {BadRegHi, BadRegLo, 48'd0};
          reply_len  = 4'd2;
        end
      endcase
    end
  end

  // State registers, updated once per command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      debug_q <= 1'b0;
      led_q   <= 1'b0;
      speed_q <= '0;
    end else if (fire_i) begin
      armed_q <= armed_d;
      debug_q <= debug_d;
      led_q   <= led_d;
      speed_q <= speed_d;
    end
  end

  // Result reflects state after this command
  always_comb begin
    res_o.reply_data    = reply_data;
    res_o.reply_length  = reply_len;
    res_o.drive         = speed_d;
    res_o.drive_updated = upd;
    res_o.is_armed      = armed_d;
    res_o.in_debug      = debug_d;
    res_o.led_on        = debug_d ? led_d : armed_d;
  end

endmodule

// ===== design/motor_bridge_command_unit.sv =====
// Motor bridge command unit: top level with input stage, execution and result register.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one decoded host command
//   word: mode, argument byte, four raw speed words and current telemetry.
//   Output channel (out_valid_o / out_ready_i) returns one result word per
//   command: register-read reply bytes and length, stored drive speeds, an
//   update pulse, armed and debug flags and the LED state.
//   The word waits in the input register while the command logic works on
//   it, is loaded into the result register when the pipeline moves, and
//   out_valid_o is high from then on.
//   Throughput is one command per cycle; the input register and the result
//   register form a two-stage pipeline that moves whenever the result
//   register is empty or being taken.
//   When the receiver stalls, the result holds, the input register fills,
//   and in_ready_o drops until the receiver takes a word.
//   Reset clears both stages, disarms, leaves debug mode, clears the LED
//   request and zeroes all four speeds.
module motor_bridge_command_unit
  import mbcu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  arg_byte_i,
  input  logic [15:0] speed_a_i,
  input  logic [15:0] speed_b_i,
  input  logic [15:0] speed_c_i,
  input  logic [15:0] speed_d_i,
  input  logic [15:0] battery_mv_i,
  input  logic [15:0] esc_ma_i,
  input  logic [15:0] host_ma_i,
  input  logic [15:0] command_echo_i,
  input  logic [15:0] link_check_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] reply_data_o,
  output logic [3:0]  reply_length_o,
  output logic [10:0] drive_a_o,
  output logic [10:0] drive_b_o,
  output logic [10:0] drive_c_o,
  output logic [10:0] drive_d_o,
  output logic        drive_updated_o,
  output logic        is_armed_o,
  output logic        in_debug_o,
  output logic        led_on_o
);

  mbcu_cmd_t in_cmd, stage_cmd;
  mbcu_res_t res, res_q;
  logic      stage_valid;
  logic      advance;
  logic      fire;
  logic      out_valid_q, out_valid_d;

  // Pack input fields
  always_comb begin
    in_cmd.mode         = mode_i;
    in_cmd.arg_byte     = arg_byte_i;
    in_cmd.speed[0]     = speed_a_i;
    in_cmd.speed[1]     = speed_b_i;
    in_cmd.speed[2]     = speed_c_i;
    in_cmd.speed[3]     = speed_d_i;
    in_cmd.battery_mv   = battery_mv_i;
    in_cmd.esc_ma       = esc_ma_i;
    in_cmd.host_ma      = host_ma_i;
    in_cmd.command_echo = command_echo_i;
    in_cmd.link_check   = link_check_i;
  end

  // Pipeline moves when the result register is free or being drained
  assign advance = !out_valid_q || out_ready_i;
  assign fire    = stage_valid && advance;

  mbcu_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (in_cmd),
    .advance_i     (advance),
    .stage_valid_o (stage_valid),
    .cmd_o         (stage_cmd)
  );

  mbcu_exec u_exec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .cmd_i  (stage_cmd),
    .res_o  (res)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = stage_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  // Unpack result word
  assign out_valid_o     = out_valid_q;
  assign reply_data_o    = res_q.reply_data;
  assign reply_length_o  = res_q.reply_length;
  assign drive_a_o       = res_q.drive[0];
  assign drive_b_o       = res_q.drive[1];
  assign drive_c_o       = res_q.drive[2];
  assign drive_d_o       = res_q.drive[3];
  assign drive_updated_o = res_q.drive_updated;
  assign is_armed_o      = res_q.is_armed;
  assign in_debug_o      = res_q.in_debug;
  assign led_on_o        = res_q.led_on;

endmodule

// ===== dv/motor_bridge_command_unit_tb.sv =====
// Testbench for the motor bridge command unit: random and directed commands, scored results.
`timescale 1ns / 1ps

module motor_bridge_command_unit_tb;
  import mbcu_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int RandomCmds = 400;

  // One queued command plus a request to let the pipe drain before sending it
  typedef struct {
    mbcu_cmd_t cmd;
    bit        drain_first;
  } cmd_entry_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  mode_i = '0;
  logic [7:0]  arg_byte_i = '0;
  logic [15:0] speed_a_i = '0;
  logic [15:0] speed_b_i = '0;
  logic [15:0] speed_c_i = '0;
  logic [15:0] speed_d_i = '0;
  logic [15:0] battery_mv_i = '0;
  logic [15:0] esc_ma_i = '0;
  logic [15:0] host_ma_i = '0;
  logic [15:0] command_echo_i = '0;
  logic [15:0] link_check_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] reply_data_o;
  logic [3:0]  reply_length_o;
  logic [10:0] drive_a_o;
  logic [10:0] drive_b_o;
  logic [10:0] drive_c_o;
  logic [10:0] drive_d_o;
  logic        drive_updated_o;
  logic        is_armed_o;
  logic        in_debug_o;
  logic        led_on_o;

  motor_bridge_command_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .arg_byte_i     (arg_byte_i),
    .speed_a_i      (speed_a_i),
    .speed_b_i      (speed_b_i),
    .speed_c_i      (speed_c_i),
    .speed_d_i      (speed_d_i),
    .battery_mv_i   (battery_mv_i),
    .esc_ma_i       (esc_ma_i),
    .host_ma_i      (host_ma_i),
    .command_echo_i (command_echo_i),
    .link_check_i   (link_check_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .reply_data_o   (reply_data_o),
    .reply_length_o (reply_length_o),
    .drive_a_o      (drive_a_o),
    .drive_b_o      (drive_b_o),
    .drive_c_o      (drive_c_o),
    .drive_d_o      (drive_d_o),
    .drive_updated_o(drive_updated_o),
    .is_armed_o     (is_armed_o),
    .in_debug_o     (in_debug_o),
    .led_on_o       (led_on_o)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cmd_entry_t cmd_backlog[$];
  mbcu_res_t  expected_results[$];
  int         total_cmds = 0;
  int         accepted_cnt = 0;
  int         checked_cnt = 0;
  int         err_cnt = 0;
  int         cycle_cnt = 0;
  int         drain_cnt = 0;
  int         speed_writes = 0;
  int         read_cnt = 0;
  int         bad_reg_cnt = 0;
  logic       in_taken = 1'b0;
  int         send_gap = 0;
  int         stall_left = 0;
  logic       quiet;

  // Shadow copy of the block state
  logic             armed = 1'b0;
  logic             dbg_mode = 1'b0;
  logic             led_req = 1'b0;
  logic [3:0][10:0] motor_spd = '0;

  // Regular stretches with no idling on either side
  assign quiet = (cycle_cnt % 2000) < 400;

  // Cycle count and timeout
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_cnt,
               expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (quiet || p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Apply one command to the shadow state and return the result it should give
  function automatic mbcu_res_t apply_command(input mbcu_cmd_t c);
    mbcu_res_t r;
    logic      fits;
    r = '0;
    fits = 1'b1;
    for (int i = 0; i < 4; i++) if (c.speed[i] > SpeedMax) fits = 1'b0;
    case (c.mode)
      MODE_DEBUG: begin
        dbg_mode = (c.arg_byte == FlagOn) && !armed;
        if (!dbg_mode) begin
          armed = 1'b0;
          motor_spd = '0;
          r.drive_updated = 1'b1;
        end
      end
      MODE_ARM: begin
        armed = (c.arg_byte == FlagOn);
        motor_spd = '0;
        r.drive_updated = 1'b1;
      end
      MODE_SPEED: begin
        if (armed && fits) begin
          for (int i = 0; i < 4; i++) motor_spd[i] = c.speed[i][10:0];
          r.drive_updated = 1'b1;
          speed_writes++;
        end
      end
      MODE_STOP: begin
        motor_spd = '0;
        r.drive_updated = 1'b1;
      end
      MODE_LED: led_req = (c.arg_byte == FlagOn);
      MODE_READ: begin
        read_cnt++;
        // reply bytes are packed from the top, words high byte first
        case (c.arg_byte)
          RegVersion: begin
            r.reply_data = {VersionHi, VersionLo, 48'd0};
            r.reply_length = 4'd2;
          end
          RegBattery: begin
            r.reply_data = {c.battery_mv, 48'd0};
            r.reply_length = 4'd2;
          end
          RegEscCur: begin
            r.reply_data = {c.esc_ma, 48'd0};
            r.reply_length = 4'd2;
          end
          RegHostCur: begin
            r.reply_data = {c.host_ma, 48'd0};
            r.reply_length = 4'd2;
          end
          RegPower: begin
            r.reply_data = {c.battery_mv, c.esc_ma, c.host_ma, 16'd0};
            r.reply_length = 4'd6;
          end
          RegArmed: begin
            r.reply_data = {7'd0, armed, 56'd0};
            r.reply_length = 4'd1;
          end
          RegSpeeds: begin
            r.reply_data = {5'd0, motor_spd[0], 5'd0, motor_spd[1],
                            5'd0, motor_spd[2], 5'd0, motor_spd[3]};
            r.reply_length = 4'd8;
          end
          RegCheck: begin
            r.reply_data = {c.command_echo, c.link_check, 32'd0};
            r.reply_length = 4'd4;
          end
          RegDebug: begin
            r.reply_data = {7'd0, dbg_mode, 56'd0};
            r.reply_length = 4'd1;
          end
          default: begin
            r.reply_data = {BadRegHi, BadRegLo, 48'd0};
            r.reply_length = 4'd2;
            bad_reg_cnt++;
          end
        endcase
      end
      default: ;
    endcase
    r.drive = motor_spd;
    r.is_armed = armed;
    r.in_debug = dbg_mode;
    r.led_on = dbg_mode ? led_req : armed;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR cycle %0d result %0d: %s got %0h, expected %0h", cycle_cnt,
             checked_cnt, what, got, want);
    err_cnt++;
  endtask

  // Input driver: holds the word until it is taken, then idles or sends the next
  always @(negedge clk_i) begin
    cmd_entry_t e;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && !in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (cmd_backlog.size() != 0 &&
                   !(cmd_backlog[0].drain_first && expected_results.size() != 0)) begin
        e = cmd_backlog.pop_front();
        mode_i <= e.cmd.mode;
        arg_byte_i <= e.cmd.arg_byte;
        speed_a_i <= e.cmd.speed[0];
        speed_b_i <= e.cmd.speed[1];
        speed_c_i <= e.cmd.speed[2];
        speed_d_i <= e.cmd.speed[3];
        battery_mv_i <= e.cmd.battery_mv;
        esc_ma_i <= e.cmd.esc_ma;
        host_ma_i <= e.cmd.host_ma;
        command_echo_i <= e.cmd.command_echo;
        link_check_i <= e.cmd.link_check;
        in_valid_i <= 1'b1;
        send_gap = idle_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 5) == 0) stall_left = idle_len();
    end
  end

  // Monitor: predict on input accept, score on output accept
  always @(posedge clk_i) begin
    mbcu_cmd_t c;
    mbcu_res_t want;
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      c.mode = mode_i;
      c.arg_byte = arg_byte_i;
      c.speed[0] = speed_a_i;
      c.speed[1] = speed_b_i;
      c.speed[2] = speed_c_i;
      c.speed[3] = speed_d_i;
      c.battery_mv = battery_mv_i;
      c.esc_ma = esc_ma_i;
      c.host_ma = host_ma_i;
      c.command_echo = command_echo_i;
      c.link_check = link_check_i;
      expected_results.push_back(apply_command(c));
      accepted_cnt <= accepted_cnt + 1;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("word with nothing pending", reply_data_o, '0);
      end else begin
        want = expected_results.pop_front();
        if (reply_data_o !== want.reply_data)
          report_mismatch("reply_data", reply_data_o, want.reply_data);
        if (reply_length_o !== want.reply_length)
          report_mismatch("reply_length", reply_length_o, want.reply_length);
        if (drive_a_o !== want.drive[0]) report_mismatch("drive_a", drive_a_o, want.drive[0]);
        if (drive_b_o !== want.drive[1]) report_mismatch("drive_b", drive_b_o, want.drive[1]);
        if (drive_c_o !== want.drive[2]) report_mismatch("drive_c", drive_c_o, want.drive[2]);
        if (drive_d_o !== want.drive[3]) report_mismatch("drive_d", drive_d_o, want.drive[3]);
        if (drive_updated_o !== want.drive_updated)
          report_mismatch("drive_updated", drive_updated_o, want.drive_updated);
        if (is_armed_o !== want.is_armed)
          report_mismatch("is_armed", is_armed_o, want.is_armed);
        if (in_debug_o !== want.in_debug)
          report_mismatch("in_debug", in_debug_o, want.in_debug);
        if (led_on_o !== want.led_on) report_mismatch("led_on", led_on_o, want.led_on);
      end
      checked_cnt++;
    end
  end

  // Command with the given mode and argument, everything else random
  function automatic mbcu_cmd_t make_cmd(input logic [2:0] m, input logic [7:0] a);
    mbcu_cmd_t c;
    c.mode = m;
    c.arg_byte = a;
    for (int i = 0; i < 4; i++) c.speed[i] = 16'($urandom_range(0, 65535));
    c.battery_mv = rand_word();
    c.esc_ma = rand_word();
    c.host_ma = rand_word();
    c.command_echo = rand_word();
    c.link_check = rand_word();
    return c;
  endfunction

  // Speed command, in range or with one lane over the limit
  function automatic mbcu_cmd_t speed_cmd(input bit in_range);
    mbcu_cmd_t c;
    c = make_cmd(MODE_SPEED, 8'($urandom_range(0, 255)));
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 7))
        0:       c.speed[i] = 16'd0;
        1:       c.speed[i] = SpeedMax;
        default: c.speed[i] = 16'($urandom_range(0, 2047));
      endcase
    end
    if (!in_range) c.speed[2'($urandom_range(0, 3))] = 16'($urandom_range(2048, 65535));
    return c;
  endfunction

  function automatic logic [7:0] flag_arg(input bit on);
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return on ? FlagOn : 8'h00;
  endfunction

  function automatic logic [7:0] pick_reg();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(9, 255));
    return 8'($urandom_range(0, 8));
  endfunction

  task automatic queue_cmd(input mbcu_cmd_t c, input bit drain);
    cmd_entry_t e;
    e.cmd = c;
    e.drain_first = drain;
    cmd_backlog.push_back(e);
    total_cmds++;
    if (drain) drain_cnt++;
  endtask

  initial begin
    mbcu_cmd_t c;
    int        random_cnt;
    int        k;

    // Directed: flags, debug rules, speed limits, every register, ignored codes
    queue_cmd(make_cmd(MODE_READ, RegVersion), 1'b0);
    queue_cmd(make_cmd(MODE_READ, RegDebug), 1'b0);
    queue_cmd(make_cmd(MODE_DEBUG, FlagOn), 1'b0);
    queue_cmd(make_cmd(MODE_LED, FlagOn), 1'b0);
    queue_cmd(make_cmd(MODE_READ, RegDebug), 1'b0);
    queue_cmd(make_cmd(MODE_ARM, FlagOn), 1'b0);
    queue_cmd(make_cmd(MODE_DEBUG, FlagOn), 1'b0);
    queue_cmd(make_cmd(MODE_ARM, FlagOn), 1'b0);
    c = make_cmd(MODE_SPEED, 8'hFF);
    c.speed = {4{SpeedMax}};
    queue_cmd(c, 1'b0);
    queue_cmd(make_cmd(MODE_READ, RegSpeeds), 1'b0);
    c.speed[2] = SpeedMax + 16'd1;
    queue_cmd(c, 1'b0);
    c.speed = {4{16'hFFFF}};
    queue_cmd(c, 1'b0);
    queue_cmd(make_cmd(MODE_READ, RegArmed), 1'b0);
    queue_cmd(make_cmd(MODE_STOP, 8'h00), 1'b0);
    c.speed = '0;
    queue_cmd(c, 1'b0);
    queue_cmd(make_cmd(MODE_ARM, 8'h02), 1'b0);
    queue_cmd(speed_cmd(1'b1), 1'b0);
    c = make_cmd(MODE_READ, RegPower);
    {c.battery_mv, c.esc_ma, c.host_ma} = {16'hFFFF, 16'h0000, 16'hFFFF};
    queue_cmd(c, 1'b0);
    queue_cmd(make_cmd(MODE_READ, RegBattery), 1'b0);
    queue_cmd(make_cmd(MODE_READ, RegEscCur), 1'b0);
    queue_cmd(make_cmd(MODE_READ, RegHostCur), 1'b0);
    queue_cmd(make_cmd(MODE_READ, RegCheck), 1'b0);
    queue_cmd(make_cmd(MODE_READ, 8'hFF), 1'b0);
    queue_cmd(make_cmd(MODE_SPARE_A, FlagOn), 1'b0);
    queue_cmd(make_cmd(MODE_SPARE_B, 8'h00), 1'b0);
    queue_cmd(make_cmd(MODE_LED, 8'h00), 1'b0);

    // Random: mostly armed driving sessions and debug sessions, some noise
    random_cnt = 0;
    while (random_cnt < RandomCmds) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          queue_cmd(make_cmd(MODE_ARM, flag_arg(1'b1)), random_cnt == 0);
          k = $urandom_range(2, 10);
          for (int i = 0; i < k; i++) begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4: queue_cmd(speed_cmd(1'b1), $urandom_range(0, 99) == 0);
              5:             queue_cmd(speed_cmd(1'b0), 1'b0);
              6, 7:          queue_cmd(make_cmd(MODE_READ, pick_reg()), 1'b0);
              8:             queue_cmd(make_cmd(MODE_LED, flag_arg(1'b1)), 1'b0);
              default:       queue_cmd(make_cmd(MODE_STOP, flag_arg(1'b0)), 1'b0);
            endcase
          end
          case ($urandom_range(0, 2))
            0:       queue_cmd(make_cmd(MODE_STOP, flag_arg(1'b0)), 1'b0);
            1:       queue_cmd(make_cmd(MODE_ARM, flag_arg(1'b0)), 1'b0);
            default: queue_cmd(make_cmd(MODE_DEBUG, flag_arg(1'b1)), 1'b0);
          endcase
          random_cnt += k + 2;
        end
        6, 7: begin
          queue_cmd(make_cmd(MODE_DEBUG, flag_arg(1'b1)), 1'b0);
          k = $urandom_range(1, 6);
          for (int i = 0; i < k; i++) begin
            case ($urandom_range(0, 5))
              0, 1:    queue_cmd(make_cmd(MODE_LED, flag_arg(1'($urandom_range(0, 1)))), 1'b0);
              2, 3:    queue_cmd(make_cmd(MODE_READ, pick_reg()), 1'b0);
              4:       queue_cmd(make_cmd(MODE_ARM, flag_arg(1'($urandom_range(0, 1)))), 1'b0);
              default: queue_cmd(speed_cmd(1'($urandom_range(0, 1))), 1'b0);
            endcase
          end
          queue_cmd(make_cmd(MODE_DEBUG, flag_arg(1'b0)), 1'b0);
          random_cnt += k + 2;
        end
        default: begin
          c = make_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
          queue_cmd(c, 1'b0);
          if (c.mode <= MODE_READ) random_cnt++;
        end
      endcase
    end

    // Reset, then let the driver run until everything has been scored
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (accepted_cnt != total_cmds) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (expected_results.size() != 0)
      report_mismatch("results never delivered", expected_results.size(), 0);
    $display("Scored %0d commands (%0d drain pauses, %0d speed writes applied),",
             checked_cnt, drain_cnt, speed_writes);
    $display("  with %0d register reads of which %0d hit unknown addresses.",
             read_cnt, bad_reg_cnt);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
